[design/cfuv_pkg.sv]
// cfuv_pkg: shared types and constants for the cube-map face / uv block.
// No dependencies.
`default_nettype none
package cfuv_pkg;
  typedef enum logic [2:0] {
    FACE_PX = 3'd0, FACE_NX = 3'd1, FACE_PY = 3'd2,
    FACE_NY = 3'd3, FACE_PZ = 3'd4, FACE_NZ = 3'd5
  } face_t;
  localparam int FACE_W = 3;
endpackage
`default_nettype wire

[design/cubemap_face_uv.sv]
// cubemap_face_uv: top level, face selection stage plus a chain of divider cells.
// Depends on cfuv_pkg and cfuv_div_cell.
//
// Usage: drive dir_x/dir_y/dir_z and pulse start; busy is always low, so an
// item is taken at every edge where start is high. One item per cycle.
// The first stage picks the major axis and face, forms numerator
// (c + m) << FRAC_BITS and denominator 2*m. Then a row of
// COORD_WIDTH+FRAC_BITS+1 cells each produces one quotient bit of u and v
// in parallel. Each item passes through the entry register and then every
// cell register of that chain. Results appear on face, tex_u,
// tex_v, zero_vector with done high for one cycle; the receiver cannot stall.
// A zero vector gives face -Z, zero coordinates and zero_vector set.
// Reset clears the valid bits of the pipeline; payload is not reset.
`default_nettype none
module cubemap_face_uv
  import cfuv_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [COORD_WIDTH-1:0] dir_x,
  input  wire logic [COORD_WIDTH-1:0] dir_y,
  input  wire logic [COORD_WIDTH-1:0] dir_z,
  output logic                        done,
  output logic [FACE_W-1:0]           face,
  output logic [FRAC_BITS:0]          tex_u,
  output logic [FRAC_BITS:0]          tex_v,
  output logic                        zero_vector
);
  localparam int MW = COORD_WIDTH + 1;            // width of m; 2*m takes MW+1 bits
  localparam int QW = COORD_WIDTH + FRAC_BITS + 1; // numerator width
  localparam int NC = QW;

  logic signed [COORD_WIDTH:0] x, y, z, uc, vc;
  logic [COORD_WIDTH:0] ax, ay, az, m;
  logic xmaj, ymaj, zmaj;
  face_t f;

  // face selection, first match wins
  always_comb begin
    x = {dir_x[COORD_WIDTH-1], dir_x};
    y = {dir_y[COORD_WIDTH-1], dir_y};
    z = {dir_z[COORD_WIDTH-1], dir_z};
    ax = x[COORD_WIDTH] ? -x : x;
    ay = y[COORD_WIDTH] ? -y : y;
    az = z[COORD_WIDTH] ? -z : z;
    xmaj = (ax >= ay) && (ax >= az);
    ymaj = (ay >= ax) && (ay >= az);
    zmaj = (az >= ax) && (az >= ay);
    m = az; uc = -x; vc = y; f = FACE_NZ;
    priority if (zmaj && !z[COORD_WIDTH] && z != 0) begin
      m = az; uc = x; vc = y; f = FACE_PZ;
    end else if (zmaj) begin
      m = az; uc = -x; vc = y; f = FACE_NZ;
    end else if (ymaj && !y[COORD_WIDTH] && y != 0) begin
      m = ay; uc = x; vc = -z; f = FACE_PY;
    end else if (ymaj) begin
      m = ay; uc = x; vc = z; f = FACE_NY;
    end else if (!x[COORD_WIDTH] && x != 0) begin
      m = ax; uc = -z; vc = y; f = FACE_PX;
    end else begin
      m = ax; uc = z; vc = y; f = FACE_NX;
    end
  end

  logic          vld  [NC+1];
  logic [MW:0]   den  [NC+1];
  logic [MW:0]   ru   [NC+1];
  logic [MW:0]   rv   [NC+1];
  logic [QW-1:0] nu   [NC+1];
  logic [QW-1:0] nv   [NC+1];
  logic [QW-1:0] qu   [NC+1];
  logic [QW-1:0] qv   [NC+1];
  face_t         fc   [NC+1];
  logic          zr   [NC+1];
  logic [COORD_WIDTH+1:0] su, sv;

  // entry register; zero vector gets den 1 and numerator 0
  always_comb begin
    su = {uc[COORD_WIDTH], uc} + {1'b0, m};
    sv = {vc[COORD_WIDTH], vc} + {1'b0, m};
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= start;
    fc[0] <= f;
    zr[0] <= (m == 0);
    den[0] <= (m == 0) ? {{MW{1'b0}}, 1'b1} : {m, 1'b0};
    nu[0] <= (m == 0) ? '0 : {su[COORD_WIDTH:0], {FRAC_BITS{1'b0}}};
    nv[0] <= (m == 0) ? '0 : {sv[COORD_WIDTH:0], {FRAC_BITS{1'b0}}};
    ru[0] <= '0;
    rv[0] <= '0;
    qu[0] <= '0;
    qv[0] <= '0;
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    cfuv_div_cell #(.MW(MW), .QW(QW)) u_cell (
      .clk(clk), .rst(rst), .vld_in(vld[i]), .den_in(den[i]), .ru_in(ru[i]),
      .rv_in(rv[i]), .nu_in(nu[i]), .nv_in(nv[i]), .qu_in(qu[i]), .qv_in(qv[i]),
      .face_in(fc[i]), .zero_in(zr[i]),
      .vld_out(vld[i+1]), .den_out(den[i+1]), .ru_out(ru[i+1]), .rv_out(rv[i+1]),
      .nu_out(nu[i+1]), .nv_out(nv[i+1]), .qu_out(qu[i+1]), .qv_out(qv[i+1]),
      .face_out(fc[i+1]), .zero_out(zr[i+1])
    );
  end

  assign busy        = 1'b0;
  assign done        = vld[NC];
  assign face        = fc[NC];
  assign tex_u       = qu[NC][FRAC_BITS:0];
  assign tex_v       = qv[NC][FRAC_BITS:0];
  assign zero_vector = zr[NC];

  a_zero_face: assert property (@(posedge clk) disable iff (rst)
    done && zero_vector |-> face == FACE_NZ && tex_u == 0 && tex_v == 0)
    else $error("zero vector result malformed");
  a_u_range: assert property (@(posedge clk) disable iff (rst)
    done |-> tex_u <= (1 << FRAC_BITS) && tex_v <= (1 << FRAC_BITS))
    else $error("coordinate out of range");
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    done |-> face <= FACE_NZ)
    else $error("face code out of range");
endmodule
`default_nettype wire

[design/cfuv_div_cell.sv]
// cfuv_div_cell: one restoring-division step for the u and v quotients.
// Depends on cfuv_pkg.
`default_nettype none
module cfuv_div_cell
  import cfuv_pkg::*;
#(
  parameter int MW = 17,
  parameter int QW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          vld_in,
  input  wire logic [MW:0]   den_in,
  input  wire logic [MW:0]   ru_in,
  input  wire logic [MW:0]   rv_in,
  input  wire logic [QW-1:0] nu_in,
  input  wire logic [QW-1:0] nv_in,
  input  wire logic [QW-1:0] qu_in,
  input  wire logic [QW-1:0] qv_in,
  input  wire face_t         face_in,
  input  wire logic          zero_in,
  output logic               vld_out,
  output logic [MW:0]        den_out,
  output logic [MW:0]        ru_out,
  output logic [MW:0]        rv_out,
  output logic [QW-1:0]      nu_out,
  output logic [QW-1:0]      nv_out,
  output logic [QW-1:0]      qu_out,
  output logic [QW-1:0]      qv_out,
  output face_t              face_out,
  output logic               zero_out
);
  logic [MW+1:0] su, sv, tu, tv;

  // shift in next numerator bit, trial subtract
  always_comb begin
    su = {ru_in, nu_in[QW-1]};
    sv = {rv_in, nv_in[QW-1]};
    tu = su - {1'b0, den_in};
    tv = sv - {1'b0, den_in};
  end

  // valid bit cleared by reset
  always_ff @(posedge clk) begin
    if (rst) vld_out <= 1'b0;
    else     vld_out <= vld_in;
  end

  always_ff @(posedge clk) begin
    den_out  <= den_in;
    face_out <= face_in;
    zero_out <= zero_in;
    nu_out   <= {nu_in[QW-2:0], 1'b0};
    nv_out   <= {nv_in[QW-2:0], 1'b0};
    ru_out   <= tu[MW+1] ? su[MW:0] : tu[MW:0];
    rv_out   <= tv[MW+1] ? sv[MW:0] : tv[MW:0];
    qu_out   <= {qu_in[QW-2:0], ~tu[MW+1]};
    qv_out   <= {qv_in[QW-2:0], ~tv[MW+1]};
  end
endmodule
`default_nettype wire

[test/cubemap_face_uv_chk.sv]
// cubemap_face_uv_chk: watches the item and result channels of cubemap_face_uv,
// predicts face/u/v for each accepted item and compares. Depends on cfuv_pkg.
`timescale 1ns / 100ps
module cubemap_face_uv_chk
  import cfuv_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic                   busy,
  input  wire logic [COORD_WIDTH-1:0] dir_x,
  input  wire logic [COORD_WIDTH-1:0] dir_y,
  input  wire logic [COORD_WIDTH-1:0] dir_z,
  input  wire logic                   done,
  input  wire logic [FACE_W-1:0]      face,
  input  wire logic [FRAC_BITS:0]     tex_u,
  input  wire logic [FRAC_BITS:0]     tex_v,
  input  wire logic                   zero_vector,
  output int                          fail_count,
  output int                          pending
);

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [FRAC_BITS:0] u;
    logic [FRAC_BITS:0] v;
    logic               zv;
  } uv_res_t;

  uv_res_t face_uv_q[$];

  assign pending = face_uv_q.size();

  // Fixed-point (c/m + 1)/2, truncated
  function automatic logic [FRAC_BITS:0] tex_coord(longint c, longint m);
    longint num;
    num = (c + m) <<< FRAC_BITS;
    return (FRAC_BITS+1)'(num / (2 * m));
  endfunction

  function automatic uv_res_t face_uv_of(logic signed [COORD_WIDTH-1:0] x,
                                         logic signed [COORD_WIDTH-1:0] y,
                                         logic signed [COORD_WIDTH-1:0] z);
    longint sx, sy, sz, ax, ay, az, m, uc, vc;
    bit xm, ym, zm;
    uv_res_t r;
    sx = x; sy = y; sz = z;
    ax = sx < 0 ? -sx : sx;
    ay = sy < 0 ? -sy : sy;
    az = sz < 0 ? -sz : sz;
    xm = ax >= ay && ax >= az;
    ym = ay >= ax && ay >= az;
    zm = az >= ax && az >= ay;
    m = 0; uc = 0; vc = 0;
    r.face = FACE_NZ;
    // later faces override earlier ones: Z beats Y beats X on ties
    if (xm && sx > 0) begin m = ax; uc = -sz; vc = sy; r.face = FACE_PX; end
    if (xm && sx <= 0) begin m = ax; uc = sz; vc = sy; r.face = FACE_NX; end
    if (ym && sy > 0) begin m = ay; uc = sx; vc = -sz; r.face = FACE_PY; end
    if (ym && sy <= 0) begin m = ay; uc = sx; vc = sz; r.face = FACE_NY; end
    if (zm && sz > 0) begin m = az; uc = sx; vc = sy; r.face = FACE_PZ; end
    if (zm && sz <= 0) begin m = az; uc = -sx; vc = sy; r.face = FACE_NZ; end
    if (m == 0) begin
      r.u = '0; r.v = '0; r.zv = 1'b1;
    end else begin
      r.u = tex_coord(uc, m); r.v = tex_coord(vc, m); r.zv = 1'b0;
    end
    return r;
  endfunction

  initial fail_count = 0;

  // Predict on accept, compare on strobe
  always @(posedge clk) begin
    uv_res_t got, want;
    if (!rst) begin
      if (done) begin
        got = '{face, tex_u, tex_v, zero_vector};
        if (face_uv_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %p", got);
        end else begin
          want = face_uv_q.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: exp %p got %p", want, got);
          end
        end
      end
      if (start && !busy)
        face_uv_q.insert(face_uv_q.size(), face_uv_of(dir_x, dir_y, dir_z));
    end
  end

endmodule

[test/cubemap_face_uv_tb.sv]
// cubemap_face_uv_tb: drives direction items into cubemap_face_uv and gives the
// verdict. Depends on cfuv_pkg, cubemap_face_uv and cubemap_face_uv_chk.
`timescale 1ns / 100ps
module cubemap_face_uv_tb;
  import cfuv_pkg::*;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int LAT = CW + FB + 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  wire busy, done, zero_vector;
  wire [FACE_W-1:0] face;
  wire [FB:0] tex_u, tex_v;
  int fail_count, pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cubemap_face_uv #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
    .clk, .rst, .start, .busy, .dir_x, .dir_y, .dir_z,
    .done, .face, .tex_u, .tex_v, .zero_vector
  );

  cubemap_face_uv_chk #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_chk (
    .clk, .rst, .start, .busy, .dir_x, .dir_y, .dir_z,
    .done, .face, .tex_u, .tex_v, .zero_vector, .fail_count, .pending
  );

  // Hold one item until it is taken; random gap before it.
  // start stays high afterwards so a zero gap gives back-to-back items.
  task automatic send_dir(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    dir_x <= x; dir_y <= y; dir_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rnd_comp();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return {1'b0, {(CW-1){1'b1}}};
      3: return CW'($urandom_range(0, 6)) - CW'(3);
      default: return CW'($urandom);
    endcase
  endfunction

  localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MAXN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] NEG1 = '1;

  initial begin
    logic [CW-1:0] a, b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: zero vector, each face, ties, zero as negative, extremes
    send_dir('0, '0, '0);
    send_dir(ONE, '0, '0);
    send_dir(NEG1, '0, '0);
    send_dir('0, ONE, '0);
    send_dir('0, NEG1, '0);
    send_dir('0, '0, ONE);
    send_dir('0, '0, NEG1);
    send_dir(MAXP, MAXP, MAXP);
    send_dir(MAXN, MAXN, MAXN);
    send_dir(MAXN, MAXP, MAXP);
    send_dir(MAXP, MAXN, '0);
    send_dir(MAXN, MAXP, NEG1);
    send_dir(MAXP, NEG1, MAXN);
    send_dir(ONE, ONE, '0);
    send_dir(NEG1, NEG1, NEG1);
    send_dir('0, MAXN, MAXP);
    send_dir(MAXN, '0, '0);
    send_dir(MAXP, '0, '0);
    send_dir(MAXN, MAXP, '0);
    send_dir('1, '1, '0);
    // pause until everything is back
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 1150; i++) begin
      a = rnd_comp();
      b = rnd_comp();
      case ($urandom_range(0, 4))
        0: send_dir(a, a, b);
        1: send_dir(b, a, a);
        2: send_dir(a, b, -a);
        default: send_dir(rnd_comp(), a, b);
      endcase
      if (i == 600) begin
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** cubemap_face_uv: PASSED **");
    end else begin
      $display("** cubemap_face_uv: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** cubemap_face_uv: FAILED **");
    $finish;
  end

endmodule
